### hw/rtl/kpd_pkg.sv
package kpd_pkg;

	localparam int CFG_IDX_W = 2;
	localparam int CFG_DATA_W = 16;
	localparam int IVL_W = 8;
	localparam int CNT_W = 16;

	localparam logic [CFG_IDX_W-1:0] REG_INTERVAL = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_LOCKOUT = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_CLEAR_KEY = 2'd2;

	localparam logic [IVL_W-1:0] RST_INTERVAL = 8'd10;
	localparam logic [CNT_W-1:0] RST_LOCKOUT = 16'd200;
	localparam int RST_CLEAR_KEY = 17;

	localparam logic [CNT_W-1:0] CNT_MAX = '1;

	localparam logic EV_PRESS = 1'b0;
	localparam logic EV_RELEASE = 1'b1;

	typedef enum logic [1:0] {
		PH_IDLE,
		PH_CONFIRM,
		PH_LOCKOUT,
		PH_RELEASE
	} phase_t;

	typedef struct packed {
		logic valid;
		logic kind;
	} evt_t;

endpackage

### hw/rtl/kpd_enc.sv
module kpd_enc
	import kpd_pkg::*;
#(
	parameter int N = 25,
	parameter int KEY_W = 5
) (
	input  logic [N-1:0]     matrix,
	output logic             found,
	output logic [KEY_W-1:0] pos
);

	always_comb begin
		found = |matrix;
		pos = '0;
		for (int i = N - 1; i >= 0; i--) begin
			if (matrix[i]) begin
				pos = KEY_W'(i);
			end
		end
	end

endmodule

### hw/rtl/kpd_ctrl.sv
module kpd_ctrl
	import kpd_pkg::*;
#(
	parameter int KEY_W = 5
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	input  logic                  step,
	input  logic                  found,
	input  logic [KEY_W-1:0]      pos,
	output evt_t                  res,
	output logic [KEY_W-1:0]      res_key
);

	logic [IVL_W-1:0] interval_q;
	logic [CNT_W-1:0] lockout_q;
	logic [KEY_W-1:0] clear_key_q;

	phase_t           phase_q, phase_d;
	logic [CNT_W-1:0] tick_q, tick_d;
	logic [KEY_W-1:0] held_q, held_d;

	logic [IVL_W-1:0] ivl;
	logic [CNT_W-1:0] target;
	logic [CNT_W-1:0] tick_inc;
	logic             expire;
	logic             match;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			interval_q <= RST_INTERVAL;
			lockout_q <= RST_LOCKOUT;
			clear_key_q <= KEY_W'(RST_CLEAR_KEY);
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_INTERVAL: interval_q <= cfg_data[IVL_W-1:0];
				REG_LOCKOUT: lockout_q <= cfg_data[CNT_W-1:0];
				REG_CLEAR_KEY: clear_key_q <= cfg_data[KEY_W-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
			tick_q <= '0;
			held_q <= '0;
		end else begin
			phase_q <= phase_d;
			tick_q <= tick_d;
			held_q <= held_d;
		end
	end

	assign ivl = (interval_q == '0) ? IVL_W'(1) : interval_q;
	assign target = (phase_q == PH_LOCKOUT) ? lockout_q : CNT_W'(ivl);
	assign tick_inc = (tick_q == CNT_MAX) ? tick_q : tick_q + CNT_W'(1);
	assign expire = (tick_inc >= target);
	assign match = found && (pos == held_q);

	always_comb begin
		phase_d = phase_q;
		tick_d = tick_q;
		held_d = held_q;
		res = '0;
		res_key = held_q;
		if (step) begin
			tick_d = expire ? '0 : tick_inc;
			if (expire) begin
				unique case (phase_q)
					PH_IDLE: begin
						if (found) begin
							held_d = pos;
							phase_d = PH_CONFIRM;
						end
					end
					PH_CONFIRM: begin
						if (!match) begin
							phase_d = PH_IDLE;
						end else begin
							res.valid = 1'b1;
							res.kind = EV_PRESS;
							if (held_q == clear_key_q && lockout_q != '0) begin
								phase_d = PH_LOCKOUT;
							end else begin
								phase_d = PH_RELEASE;
							end
						end
					end
					PH_LOCKOUT: begin
						if (match) begin
							phase_d = PH_RELEASE;
						end else begin
							phase_d = PH_IDLE;
							res.valid = 1'b1;
							res.kind = EV_RELEASE;
						end
					end
					PH_RELEASE: begin
						if (!match) begin
							phase_d = PH_IDLE;
							res.valid = 1'b1;
							res.kind = EV_RELEASE;
						end
					end
					default: phase_d = PH_IDLE;
				endcase
			end
		end
	end

endmodule

### hw/rtl/keypad_scan_debounce.sv
// A tick word is captured in the input stage; when consumed, any event word it
// yields is held in the output register until taken (two register stages).
// Throughput: one tick word per cycle unless the output stalls; the input
// stage refills when empty or when the output register is empty or being drained.
// Reset (arst_n low): phase idle, tick counter and held key zero, registers to
// interval 10, lockout 200, clear key 17, both stages empty.
module keypad_scan_debounce
	import kpd_pkg::*;
#(
	parameter int ROWS = 5,
	parameter int COLS = 5,
	localparam int N = ROWS * COLS,
	localparam int KEY_W = (N > 1) ? $clog2(N) : 1
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  logic [N-1:0]          pressed_matrix,
	output logic                  out_valid,
	input  logic                  out_ready,
	output logic                  event_kind,
	output logic [KEY_W-1:0]      key_index,
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	logic             valid_s1;
	logic [N-1:0]     matrix_s1;
	logic             fire_s1;
	logic             found;
	logic [KEY_W-1:0] pos;
	evt_t             res;
	logic [KEY_W-1:0] res_key;
	logic             out_valid_q;
	logic             kind_q;
	logic [KEY_W-1:0] key_q;

	assign cfg_ready = 1'b1;
	assign fire_s1 = valid_s1 && (!out_valid_q || out_ready);
	assign in_ready = !valid_s1 || fire_s1;

	// hold the tick word until the event logic consumes it
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			matrix_s1 <= pressed_matrix;
		end
	end

	kpd_enc #(
		.N(N),
		.KEY_W(KEY_W)
	) u_enc (
		.matrix(matrix_s1),
		.found(found),
		.pos(pos)
	);

	kpd_ctrl #(
		.KEY_W(KEY_W)
	) u_ctrl (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_valid && cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.step(fire_s1),
		.found(found),
		.pos(pos),
		.res(res),
		.res_key(res_key)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (fire_s1) begin
			out_valid_q <= res.valid;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fire_s1) begin
			kind_q <= res.kind;
			key_q <= res_key;
		end
	end

	assign out_valid = out_valid_q;
	assign event_kind = kind_q;
	assign key_index = key_q;

endmodule

### hw/rtl/kpd_check.sv
module kpd_check
	import kpd_pkg::*;
#(
	parameter int ROWS = 5,
	parameter int COLS = 5,
	localparam int N = ROWS * COLS,
	localparam int KEY_W = (N > 1) ? $clog2(N) : 1
) (
	input logic                  clk,
	input logic                  arst_n,
	input logic                  in_valid,
	input logic                  in_ready,
	input logic                  out_valid,
	input logic                  out_ready,
	input logic                  event_kind,
	input logic [KEY_W-1:0]      key_index
);

	logic             seen_q;
	logic             last_kind_q;
	logic [KEY_W-1:0] last_key_q;

	// track the last delivered event word
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seen_q <= 1'b0;
			last_kind_q <= EV_RELEASE;
			last_key_q <= '0;
		end else if (out_valid && out_ready) begin
			seen_q <= 1'b1;
			last_kind_q <= event_kind;
			last_key_q <= key_index;
		end
	end

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(event_kind) && $stable(key_index))
		else $error("event word changed while stalled");

	a_key_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> key_index <= KEY_W'(N - 1))
		else $error("key index out of range");

	a_alternate: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_ready && seen_q |->
			event_kind != last_kind_q &&
			(event_kind == EV_PRESS || key_index == last_key_q))
		else $error("press and release out of order");

	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_ready |-> out_valid && !out_ready)
		else $error("input stalled without output backpressure");

	a_first_press: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !seen_q |-> event_kind == EV_PRESS)
		else $error("release before any press");

endmodule

bind keypad_scan_debounce kpd_check #(
	.ROWS(ROWS),
	.COLS(COLS)
) u_check (.*);
